@@ design/bqe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_pkg
// Shared constants, types and helpers for the biquad cascade equalizer.
// ----------------------------------------------------------------------------
package bqe_pkg;

	// Cascade geometry and number formats
	localparam int NUM_SECTIONS = 8;
	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 32;
	localparam int FRAC_BITS    = COEF_BITS - 4;
	localparam int NUM_TAPS     = 5;

	// Field widths of a transaction
	localparam int BAND_W = 3;
	localparam int SLOT_W = 3;

	// Stream payload widths, padded to whole bytes
	localparam int IN_FIELDS_W = SAMPLE_BITS + BAND_W + SLOT_W + COEF_BITS;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

	// Storage sizing
	localparam int SEC_W       = $clog2(NUM_SECTIONS);
	localparam int HIST_DEPTH  = NUM_SECTIONS + 1;
	localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
	localparam int COEF_DEPTH  = NUM_SECTIONS * NUM_TAPS;
	localparam int COEF_ADDR_W = $clog2(COEF_DEPTH);
	localparam int TAP_W       = 3;

	// Arithmetic widths: exact products, five-term sum, rounded result
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RES_W  = ACC_W - FRAC_BITS;

	// Tap codes, in the order the taps are accumulated
	localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
	localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
	localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
	localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
	localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

	// Slot codes of a coefficient write
	localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(NUM_TAPS);

	// Unity gain b0 and the half-LSB rounding offset
	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0]     RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                  coef_wr;
		logic                  load;
		logic                  issue;
		logic [TAP_W-1:0]      tap;
		logic [SEC_W-1:0]      sec;
		logic                  round;
		logic                  commit;
		logic [HIST_IDX_W-1:0] idx;
		logic                  clear_hist;
		logic                  out_load;
		logic                  blowup;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic ovf;
	} dp_stat_t;

	// Coefficient table address of one tap of one section
	function automatic logic [COEF_ADDR_W-1:0] coef_addr(input logic [SEC_W-1:0] sec,
			input logic [TAP_W-1:0] tap);
		coef_addr = COEF_ADDR_W'(sec) * COEF_ADDR_W'(NUM_TAPS) + COEF_ADDR_W'(tap);
	endfunction

endpackage
`default_nettype wire

@@ design/bqe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_datapath
// Coefficient table, history banks, shared multiplier and accumulator,
// rounding with range check, and the output register.
// ----------------------------------------------------------------------------
module bqe_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bqe_pkg::sample_t               sample_in,
	input  wire logic [bqe_pkg::BAND_W-1:0]     band,
	input  wire logic [bqe_pkg::SLOT_W-1:0]     coef_slot,
	input  wire bqe_pkg::coef_t                 coef_value,
	input  wire bqe_pkg::dp_cmd_t               cmd,
	output bqe_pkg::dp_stat_t                   stat,
	output bqe_pkg::sample_t                    sample_out,
	output logic                                blowup
);
	import bqe_pkg::*;

	// Coefficient table with per-entry valid bits (invalid reads as reset value)
	coef_t                  coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]  coef_vld_q;
	logic [COEF_ADDR_W-1:0] wr_addr;
	logic [COEF_ADDR_W-1:0] rd_addr;
	logic                   coef_we;

	// History banks: the even bank holds x1 of each entry, the odd bank x2
	sample_t                even_mem [HIST_DEPTH];
	sample_t                odd_mem  [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]  even_vld_q;
	logic [HIST_DEPTH-1:0]  odd_vld_q;
	logic [HIST_IDX_W-1:0]  hist_addr;
	logic                   odd_sel;

	// Per-transaction scratch: section inputs and previous x1 values
	sample_t                val_buf_q [HIST_DEPTH];
	sample_t                x1_buf_q  [HIST_DEPTH];
	sample_t                cur_x_q;

	// Read stage
	logic                   vld_s1;
	coef_t                  coef_rd_s1;
	logic                   coef_vld_s1;
	sample_t                hist_rd_s1;
	logic                   hist_vld_s1;
	logic [TAP_W-1:0]       tap_s1;
	logic [SEC_W-1:0]       sec_s1;

	// Multiply stage
	logic                   vld_s2;
	logic                   sub_s2;
	logic                   first_s2;
	logic signed [PROD_W-1:0] prod_s2;

	sample_t                samp_op;
	coef_t                  coef_op;
	logic signed [PROD_W-1:0] prod_c;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [RES_W-1:0] res_full;
	sample_t                res;
	logic [HIST_IDX_W-1:0]  res_idx;

	sample_t                out_sample_q;
	logic                   out_blowup_q;

	// Address decode
	assign wr_addr   = coef_addr(SEC_W'(band), TAP_W'(coef_slot));
	assign coef_we   = cmd.coef_wr && ({1'b0, band} < (BAND_W + 1)'(NUM_SECTIONS))
		&& (coef_slot < SLOT_LIMIT);
	assign rd_addr   = coef_addr(cmd.sec, cmd.tap);
	assign odd_sel   = (cmd.tap == TAP_B2) || (cmd.tap == TAP_A2);
	assign hist_addr = ((cmd.tap == TAP_A1) || (cmd.tap == TAP_A2)) ?
		HIST_IDX_W'(cmd.sec) + HIST_IDX_W'(1) : HIST_IDX_W'(cmd.sec);

	// Coefficient storage and registered read
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[wr_addr] <= coef_value;
		end
		if (cmd.issue) begin
			coef_rd_s1 <= coef_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_we) begin
			coef_vld_q[wr_addr] <= 1'b1;
		end
	end

	// History storage: commit writes both banks, reads are registered
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			even_mem[cmd.idx] <= val_buf_q[cmd.idx];
			odd_mem[cmd.idx]  <= x1_buf_q[cmd.idx];
		end
		if (cmd.issue) begin
			hist_rd_s1 <= odd_sel ? odd_mem[hist_addr] : even_mem[hist_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_vld_q <= '0;
			odd_vld_q  <= '0;
		end else if (cmd.clear_hist) begin
			even_vld_q <= '0;
			odd_vld_q  <= '0;
		end else if (cmd.commit) begin
			even_vld_q[cmd.idx] <= 1'b1;
			odd_vld_q[cmd.idx]  <= 1'b1;
		end
	end

	// Read stage side information
	always_ff @(posedge clk) begin
		coef_vld_s1 <= coef_vld_q[rd_addr];
		hist_vld_s1 <= odd_sel ? odd_vld_q[hist_addr] : even_vld_q[hist_addr];
		tap_s1      <= cmd.tap;
		sec_s1      <= cmd.sec;
	end

	// Select operands, unwritten entries fall back to their reset values
	always_comb begin
		if (tap_s1 == TAP_B0) begin
			samp_op = cur_x_q;
		end else if (hist_vld_s1) begin
			samp_op = hist_rd_s1;
		end else begin
			samp_op = '0;
		end
		if (coef_vld_s1) begin
			coef_op = coef_rd_s1;
		end else if (tap_s1 == TAP_B0) begin
			coef_op = COEF_ONE;
		end else begin
			coef_op = '0;
		end
	end

	assign prod_c = samp_op * coef_op;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2  <= prod_c;
		sub_s2   <= (tap_s1 == TAP_A1) || (tap_s1 == TAP_A2);
		first_s2 <= tap_s1 == TAP_B0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Accumulate: the first tap of a section starts a new sum
	assign prod_ext = ACC_W'(prod_s2);
	assign acc_base = first_s2 ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= sub_s2 ? acc_base - prod_ext : acc_base + prod_ext;
		end
	end

	// Round half up, drop fraction bits, check the sample range
	assign rnd_sum  = acc_q + RND_HALF;
	assign res_full = rnd_sum[ACC_W-1:FRAC_BITS];
	assign res      = res_full[SAMPLE_BITS-1:0];
	assign stat.ovf = !((&res_full[RES_W-1:SAMPLE_BITS-1])
		|| !(|res_full[RES_W-1:SAMPLE_BITS-1]));
	assign res_idx  = HIST_IDX_W'(cmd.sec) + HIST_IDX_W'(1);

	// Hold the current section input and record every section input
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q      <= sample_in;
			val_buf_q[0] <= sample_in;
		end else if (cmd.round) begin
			cur_x_q            <= res;
			val_buf_q[res_idx] <= res;
		end
	end

	// Save the old x1 values as they come out of the history banks
	always_ff @(posedge clk) begin
		if (vld_s1 && (tap_s1 == TAP_B1)) begin
			x1_buf_q[HIST_IDX_W'(sec_s1)] <= samp_op;
		end else if (vld_s1 && (tap_s1 == TAP_A1)) begin
			x1_buf_q[HIST_IDX_W'(sec_s1) + HIST_IDX_W'(1)] <= samp_op;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sample_q <= cmd.blowup ? '0 : cur_x_q;
			out_blowup_q <= cmd.blowup;
		end
	end

	assign sample_out = out_sample_q;
	assign blowup     = out_blowup_q;

endmodule
`default_nettype wire

@@ design/bqe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_ctrl
// Sequencer: steps five taps per section through the shared multiplier,
// rounds each section, commits history unless one overflows, outputs the result.
// ----------------------------------------------------------------------------
module bqe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               kind,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	input  wire bqe_pkg::dp_stat_t  stat,
	output bqe_pkg::dp_cmd_t        cmd
);
	import bqe_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TAP    = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]            state_q;
	logic [TAP_W-1:0]      tap_q;
	logic [SEC_W-1:0]      sec_q;
	logic [HIST_IDX_W-1:0] idx_q;
	logic                  drain_q;
	logic                  blow_q;
	logic                  out_vld_q;
	logic                  in_acc;
	logic                  out_free;

	// Decode commands from the state
	always_comb begin
		s_tready       = state_q == ST_IDLE;
		in_acc         = s_tvalid && s_tready;
		out_free       = !out_vld_q || m_tready;
		cmd            = '0;
		cmd.tap        = tap_q;
		cmd.sec        = sec_q;
		cmd.idx        = idx_q;
		cmd.blowup     = blow_q;
		cmd.coef_wr    = in_acc && kind;
		cmd.load       = in_acc && !kind;
		cmd.issue      = state_q == ST_TAP;
		cmd.round      = state_q == ST_ROUND;
		cmd.clear_hist = (state_q == ST_ROUND) && stat.ovf;
		cmd.commit     = state_q == ST_COMMIT;
		cmd.out_load   = (state_q == ST_FIN) && out_free;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= TAP_B0;
			sec_q   <= '0;
			idx_q   <= '0;
			drain_q <= 1'b0;
			blow_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_TAP;
						tap_q   <= TAP_B0;
						sec_q   <= '0;
						blow_q  <= 1'b0;
					end
				end
				ST_TAP: begin
					if (tap_q == TAP_A2) begin
						state_q <= ST_DRAIN;
						tap_q   <= TAP_B0;
						drain_q <= 1'b0;
					end else begin
						tap_q <= tap_q + TAP_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= !drain_q;
					if (drain_q) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (stat.ovf) begin
						state_q <= ST_FIN;
						blow_q  <= 1'b1;
					end else if (sec_q == SEC_W'(NUM_SECTIONS - 1)) begin
						state_q <= ST_COMMIT;
						idx_q   <= '0;
					end else begin
						state_q <= ST_TAP;
						sec_q   <= sec_q + SEC_W'(1);
					end
				end
				ST_COMMIT: begin
					if (idx_q == HIST_IDX_W'(NUM_SECTIONS)) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + HIST_IDX_W'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the transaction completes downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;

endmodule
`default_nettype wire

@@ design/biquad_cascade_equalizer_unit.sv @@
// Sequence: a sample runs five taps per section through the shared multiplier,
//   drains and rounds each section, then commits the history and loads the output.
// Input is accepted only in idle; a coefficient write leaves the block idle.
//   A result still waiting downstream holds the output load until it leaves.
// Overflow ends the sample early, right after the failing section rounds.
// Reset: arst_n clears all valid bits, so table reads unity b0 and zero history.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer_unit
// Eight-section Direct Form I biquad cascade with a writable coefficient table.
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// sample_in, band, coef_slot, coef_value, zero pad
	input  wire logic [bqe_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd
	input  wire logic [0:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// sample_out
	output logic [bqe_pkg::OUT_DATA_W-1:0]         m_tdata,
	// blowup
	output logic [0:0]                             m_tuser
);
	import bqe_pkg::*;

	localparam int BAND_LSB = SAMPLE_BITS;
	localparam int SLOT_LSB = BAND_LSB + BAND_W;
	localparam int COEF_LSB = SLOT_LSB + SLOT_W;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	sample_t  sample_out;
	logic     blowup;

	// Controller
	bqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Datapath
	bqe_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (s_tdata[SAMPLE_BITS-1:0]),
		.band       (s_tdata[SLOT_LSB-1:BAND_LSB]),
		.coef_slot  (s_tdata[COEF_LSB-1:SLOT_LSB]),
		.coef_value (s_tdata[COEF_LSB+COEF_BITS-1:COEF_LSB]),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.sample_out (sample_out),
		.blowup     (blowup)
	);

	assign m_tdata    = OUT_DATA_W'(unsigned'(sample_out));
	assign m_tuser[0] = blowup;

	// An overflowed result always carries a zero sample
	ap_blowup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("blowup result with nonzero sample");

	// A loaded result is presented on the next cycle
	ap_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	// No datapath work while the block takes new transactions
	ap_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(dp_cmd.issue || dp_cmd.round || dp_cmd.commit))
		else $error("datapath busy while accepting input");

endmodule
`default_nettype wire
